/* hw/rtl/stable_priority_queue_top_defines.svh */
// Assertion macros for the stable priority queue.
// Used by stable_priority_queue_top; expects clk and rst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and codes for the stable priority queue.
// No dependencies; used by the cell and the top level.
package spq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [7:0]  burst;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* hw/rtl/spq_ifs.sv */
// Valid/ready channel interfaces for the stable priority queue.
// Standalone; carries the request and result transactions.
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  in_id;
  logic [7:0]  in_priority;
  logic [15:0] in_arrival;
  logic [7:0]  in_burst;

  modport source (output valid, action, in_id, in_priority, in_arrival, in_burst,
                  input ready);
  modport sink   (input valid, action, in_id, in_priority, in_arrival, in_burst,
                  output ready);
endinterface

interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        out_valid;
  logic [7:0]  out_id;
  logic [7:0]  out_priority;
  logic [15:0] out_arrival;
  logic [7:0]  out_burst;
  logic [4:0]  occupancy;

  modport source (output valid, status, out_valid, out_id, out_priority, out_arrival,
                  out_burst, occupancy, input ready);
  modport sink   (input valid, status, out_valid, out_id, out_priority, out_arrival,
                  out_burst, occupancy, output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One slot of the sorted shift-register queue.
// Depends on spq_pkg; instantiated in a row by stable_priority_queue_top.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  spq_pkg::rec_t      new_rec,
  input  spq_pkg::rec_t      prev_rec,
  input  logic               prev_ahead,
  input  spq_pkg::rec_t      next_rec,
  output spq_pkg::rec_t      rec,
  output logic               ahead
);

  spq_pkg::rec_t rec_r;
  spq_pkg::rec_t rec_nxt;

  // held record stays in front of the newcomer
  assign ahead = occupied &&
                 ((rec_r.prio < new_rec.prio) ||
                  ((rec_r.prio == new_rec.prio) && (rec_r.arrival < new_rec.arrival)));

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins) begin
      if (!ahead) begin
        rec_nxt = prev_ahead ? new_rec : prev_rec;
      end
    end else if (ctl.rem) begin
      rec_nxt = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

/* hw/rtl/stable_priority_queue_top.sv */
// Top level of the stable priority queue: a row of spq_cell slots plus count and result register.
// Depends on spq_pkg, spq_ifs and stable_priority_queue_top_defines.svh.
//
// Bounded queue of process records kept sorted by priority, then arrival time, with the most
// recent of fully equal records first. Every transaction (insert or remove-head) is applied to all
// slots at once: each slot compares itself against the incoming record and shifts in parallel, so a
// new transaction is taken every cycle while the result register is free or being drained. One
// result per transaction, in the cycle after acceptance. Inserts into a full queue are dropped with
// status full; removes from an empty queue return status empty and zeroed record fields.
`include "stable_priority_queue_top_defines.svh"

module stable_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_vld_r;
  logic [1:0]           status_r;
  logic                 rec_vld_r;
  spq_pkg::rec_t        rec_out_r;

  spq_pkg::rec_t        new_rec;
  spq_pkg::rec_t        cell_rec [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ahead;
  spq_pkg::cell_ctl_t   ctl;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [1:0]           status_nxt;
  logic                 rec_vld_nxt;
  spq_pkg::rec_t        rec_out_nxt;
  logic                 head_in_order;
  logic                 res_empty;

  assign in_if.ready = !out_vld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign new_rec.id      = in_if.in_id;
  assign new_rec.prio    = in_if.in_priority;
  assign new_rec.arrival = in_if.in_arrival;
  assign new_rec.burst   = in_if.in_burst;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  assign ctl.ins = accept && (in_if.action == spq_pkg::ACT_INSERT) && !full;
  assign ctl.rem = accept && (in_if.action == spq_pkg::ACT_REMOVE) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::rec_t prev_rec;
    spq_pkg::rec_t next_rec;
    logic          prev_ahead;

    if (i == 0) begin : g_first
      assign prev_rec   = new_rec;
      assign prev_ahead = 1'b1;
    end else begin : g_mid
      assign prev_rec   = cell_rec[i-1];
      assign prev_ahead = cell_ahead[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_rec = cell_rec[i];
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < count_r),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .prev_ahead (prev_ahead),
      .next_rec   (next_rec),
      .rec        (cell_rec[i]),
      .ahead      (cell_ahead[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = spq_pkg::ST_OK;
    rec_vld_nxt = 1'b1;
    rec_out_nxt = cell_rec[0];
    if (in_if.action == spq_pkg::ACT_INSERT) begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (!cell_ahead[0]) begin
          rec_out_nxt = new_rec;
        end
      end
    end else begin
      if (empty) begin
        status_nxt  = spq_pkg::ST_EMPTY;
        rec_vld_nxt = 1'b0;
        rec_out_nxt = '0;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r   <= count_nxt;
        out_vld_r <= 1'b1;
        status_r  <= status_nxt;
        rec_vld_r <= rec_vld_nxt;
        rec_out_r <= rec_out_nxt;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.status       = status_r;
  assign out_if.out_valid    = rec_vld_r;
  assign out_if.out_id       = rec_out_r.id;
  assign out_if.out_priority = rec_out_r.prio;
  assign out_if.out_arrival  = rec_out_r.arrival;
  assign out_if.out_burst    = rec_out_r.burst;
  assign out_if.occupancy    = 5'(count_r);

  assign head_in_order = (cell_rec[0].prio < cell_rec[1].prio) ||
                         ((cell_rec[0].prio == cell_rec[1].prio) &&
                          (cell_rec[0].arrival <= cell_rec[1].arrival));
  assign res_empty     = out_vld_r && (status_r == spq_pkg::ST_EMPTY);

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_remove_dec, ctl.rem, count_r == $past(count_r) - CNT_W'(1), "remove lost count")
  `SPQ_ASSERT_NOW(a_head_order, count_r >= CNT_W'(2), head_in_order, "head out of order")
  `SPQ_ASSERT_NOW(a_empty_novld, res_empty, !rec_vld_r && (rec_out_r == '0), "empty has record")

endmodule
